@@ hdl/mi3_pkg.sv @@
// Shared widths, types and the output saturation helper for the 3x3 inverse.
// No dependencies; every module of the block imports this package.
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int N_ELEM        = 9;
    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 64;
    localparam int COF_W         = 65;   // exact cofactor, |C| <= 2^63
    localparam int DET_W         = 97;   // exact determinant, |det| < 3*2^94
    localparam int MAG_W         = 96;   // determinant magnitude
    localparam int DEN_W         = 97;   // divisor 2*|det|
    localparam int QUO_W         = 33;   // quotient bits kept; bit 32 means saturate
    localparam int DIV_W         = 130;  // remainder width, holds den << 32
    localparam int THR_W         = 31;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic        [MAG_W-1:0]  mag_t;

    // Magnitude plus sign to a saturated 32-bit pattern; returns {ovf, value}.
    function automatic logic [ELEM_W:0] sat32(input logic [DEN_W-1:0] mag, input logic neg);
        logic [DEN_W-1:0] neg_lim;
        logic [DEN_W-1:0] pos_lim;
        logic [ELEM_W:0]  res;
        neg_lim = DEN_W'(64'h8000_0000);
        pos_lim = DEN_W'(64'h7FFF_FFFF);
        if (neg) begin
            if (mag > neg_lim) res = {1'b1, 32'h8000_0000};
            else               res = {1'b0, ELEM_W'(32'd0 - mag[ELEM_W-1:0])};
        end else begin
            if (mag > pos_lim) res = {1'b1, 32'h7FFF_FFFF};
            else               res = {1'b0, mag[ELEM_W-1:0]};
        end
        return res;
    endfunction

endpackage

@@ hdl/mi3_cofactor.sv @@
// Two-stage cofactor unit: 2x2 minor products, then signed cofactors.
// Depends on mi3_pkg.
module mi3_cofactor import mi3_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  elem_t a [N_ELEM],
    output logic  out_valid,
    input  logic  out_ready,
    output cof_t  cof [N_ELEM],
    output elem_t row0 [3]
);

    logic signed [PROD_W-1:0] pa_reg [N_ELEM];
    logic signed [PROD_W-1:0] pb_reg [N_ELEM];
    elem_t                    r0a_reg [3];
    cof_t                     cof_reg [N_ELEM];
    elem_t                    r0b_reg [3];
    logic [1:0]               vld_reg;
    logic                     en0, en1;

    assign en1       = !vld_reg[1] || out_ready;
    assign en0       = !vld_reg[0] || en1;
    assign in_ready  = en0;
    assign out_valid = vld_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en0) vld_reg[0] <= in_valid;
            if (en1) vld_reg[1] <= vld_reg[0];
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            localparam int R1 = (r == 0) ? 1 : 0;
            localparam int R2 = (r == 2) ? 1 : 2;
            localparam int C1 = (c == 0) ? 1 : 0;
            localparam int C2 = (c == 2) ? 1 : 2;
            localparam int K  = r * 3 + c;
            logic signed [COF_W-1:0] minor;

            assign minor = COF_W'(pa_reg[K]) - COF_W'(pb_reg[K]);

            always_ff @(posedge aclk) begin
                if (en0) begin
                    pa_reg[K] <= PROD_W'(a[R1*3+C1]) * PROD_W'(a[R2*3+C2]);
                    pb_reg[K] <= PROD_W'(a[R1*3+C2]) * PROD_W'(a[R2*3+C1]);
                end
                if (en1) begin
                    cof_reg[K] <= ((r + c) % 2 == 1) ? -minor : minor;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) r0a_reg <= a[0:2];
        if (en1) r0b_reg <= r0a_reg;
    end

    assign cof  = cof_reg;
    assign row0 = r0b_reg;

endmodule

@@ hdl/mi3_det.sv @@
// Three-stage determinant unit: split products, expansion sum, magnitude.
// Depends on mi3_pkg; carries the cofactors along for the divider.
module mi3_det import mi3_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cof_t  cof_in [N_ELEM],
    input  elem_t row0 [3],
    output logic  out_valid,
    input  logic  out_ready,
    output cof_t  cof_out [N_ELEM],
    output mag_t  dmag,
    output logic  dneg
);

    logic signed [COF_W-1:0] plo_reg [3];
    logic signed [COF_W-1:0] phi_reg [3];
    cof_t                    c3_reg [N_ELEM];
    logic signed [DET_W-1:0] det_reg;
    cof_t                    c4_reg [N_ELEM];
    mag_t                    dmag_reg;
    logic                    dneg_reg;
    cof_t                    c5_reg [N_ELEM];
    logic [2:0]              vld_reg;
    logic [2:0]              en;
    logic signed [DET_W-1:0] det_next;

    assign en[2]     = !vld_reg[2] || out_ready;
    assign en[1]     = !vld_reg[1] || en[2];
    assign en[0]     = !vld_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = vld_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    // Split each 65-bit cofactor into a 32-bit low half and a 33-bit high half.
    for (genvar j = 0; j < 3; j++) begin : g_pp
        always_ff @(posedge aclk) begin
            if (en[0]) begin
                plo_reg[j] <= COF_W'($signed({1'b0, cof_in[j][31:0]})) * COF_W'(row0[j]);
                phi_reg[j] <= COF_W'($signed(cof_in[j][COF_W-1:32])) * COF_W'(row0[j]);
            end
        end
    end

    always_comb begin
        det_next = '0;
        for (int j = 0; j < 3; j++) begin
            det_next = det_next + (DET_W'(phi_reg[j]) <<< 32) + DET_W'(plo_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) c3_reg <= cof_in;
        if (en[1]) begin
            det_reg <= det_next;
            c4_reg  <= c3_reg;
        end
        if (en[2]) begin
            dneg_reg <= det_reg[DET_W-1];
            dmag_reg <= det_reg[DET_W-1] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
            c5_reg   <= c4_reg;
        end
    end

    assign cof_out = c5_reg;
    assign dmag    = dmag_reg;
    assign dneg    = dneg_reg;

endmodule

@@ hdl/mi3_div.sv @@
// Divider pipeline: singular test and operand setup, one restoring step per
// stage for nine lanes in parallel, then saturation. Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cof_t             cof [N_ELEM],
    input  mag_t             dmag,
    input  logic             dneg,
    input  logic [THR_W-1:0] thr,
    output logic             out_valid,
    input  logic             out_ready,
    output elem_t            b [N_ELEM],
    output elem_t            det,
    output logic             singular,
    output logic             overflow
);

    localparam int NS = QUO_W + 1;

    typedef struct packed {
        logic [N_ELEM-1:0][DIV_W-1:0] rem;
        logic [N_ELEM-1:0][QUO_W-1:0] quo;
        logic [N_ELEM-1:0]            neg;
        logic [DEN_W-1:0]             den;
        logic                         sing;
        logic [ELEM_W-1:0]            det;
        logic                         det_ovf;
    } dstage_t;

    dstage_t           st_reg [NS];
    dstage_t           st_next [NS];
    logic [NS:0]       vld_reg;
    logic [NS:0]       en;
    logic [63:0]       cmag [N_ELEM];
    logic [N_ELEM-1:0] lneg;
    elem_t             b_reg [N_ELEM];
    elem_t             det_reg;
    logic              sing_reg;
    logic              ovf_reg;
    elem_t             b_next [N_ELEM];
    logic              ovf_next;

    assign en[NS] = !vld_reg[NS] || out_ready;
    for (genvar s = 0; s < NS; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int s = 1; s <= NS; s++) begin
                if (en[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Inverse element (r,c) divides the transposed cofactor C(c,r).
    for (genvar r = 0; r < 3; r++) begin : g_lr
        for (genvar c = 0; c < 3; c++) begin : g_lc
            cof_t cv;
            assign cv            = cof[c*3+r];
            assign cmag[r*3+c]   = cv[COF_W-1] ? 64'(-cv) : 64'(cv);
            assign lneg[r*3+c]   = cv[COF_W-1] ^ dneg;
        end
    end

    always_comb begin
        logic [MAG_W-1:0] thr_sh;
        logic [DEN_W-1:0] rd;
        logic [ELEM_W:0]  ds;
        thr_sh = MAG_W'(thr) << (2 * FRAC_BITS);
        rd     = (DEN_W'(dmag) + (DEN_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        ds     = sat32(rd, dneg);
        st_next[0]         = '0;
        st_next[0].sing    = (dmag <= thr_sh);
        st_next[0].den     = {dmag, 1'b0};
        st_next[0].neg     = lneg;
        st_next[0].det     = ds[ELEM_W-1:0];
        st_next[0].det_ovf = ds[ELEM_W];
        for (int k = 0; k < N_ELEM; k++) begin
            st_next[0].rem[k] = (DIV_W'(cmag[k]) << (2 * FRAC_BITS + 1)) + DIV_W'(dmag);
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s < NS; s++) begin : g_step
        localparam int BIT = QUO_W - s;
        always_comb begin
            logic [DIV_W-1:0] sh;
            sh         = DIV_W'(st_reg[s-1].den) << BIT;
            st_next[s] = st_reg[s-1];
            for (int k = 0; k < N_ELEM; k++) begin
                if (st_reg[s-1].rem[k] >= sh) begin
                    st_next[s].rem[k]      = st_reg[s-1].rem[k] - sh;
                    st_next[s].quo[k][BIT] = 1'b1;
                end
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        always_ff @(posedge aclk) begin
            if (en[s]) st_reg[s] <= st_next[s];
        end
    end

    // A set bit 32 means the quotient reached 2^32, so it saturates either way.
    always_comb begin
        logic [ELEM_W:0] q;
        ovf_next = st_reg[NS-1].det_ovf;
        for (int k = 0; k < N_ELEM; k++) begin
            q = sat32(DEN_W'(st_reg[NS-1].quo[k]), st_reg[NS-1].neg[k]);
            if (st_reg[NS-1].sing) begin
                b_next[k] = '0;
            end else begin
                b_next[k] = q[ELEM_W-1:0];
                ovf_next  = ovf_next | q[ELEM_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS]) begin
            b_reg    <= b_next;
            det_reg  <= st_reg[NS-1].det;
            sing_reg <= st_reg[NS-1].sing;
            ovf_reg  <= ovf_next;
        end
    end

    assign b        = b_reg;
    assign det      = det_reg;
    assign singular = sing_reg;
    assign overflow = ovf_reg;

endmodule

@@ hdl/mat3_inverse.sv @@
// Pipeline: 2 cofactor, 3 determinant and 35 divider and saturation stages lie between
// input transaction and result. Throughput: one matrix per cycle while the output is not
// stalled; every stage is a register with its own valid bit and bubbles close up under stall.
// Reset: aresetn, synchronous, active low; clears valids and the threshold.
// Uses mi3_pkg, mi3_cofactor, mi3_det and mi3_div.
module mat3_inverse import mi3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Threshold register write
    input  logic                     cfg_we,
    input  logic [THR_W-1:0]         cfg_wdata,
    // Input matrix
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [N_ELEM*ELEM_W-1:0] s_tdata,  // a00,a01,a02,a10,...,a22 from bit 0
    // Result
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [(N_ELEM+1)*ELEM_W-1:0] m_tdata, // b00..b22, determinant from bit 0
    output logic [1:0]               m_tuser   // singular, overflow from bit 0
);

    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_next;

    elem_t a_in [N_ELEM];
    cof_t  cof_c [N_ELEM];
    elem_t row0_c [3];
    cof_t  cof_d [N_ELEM];
    mag_t  dmag_d;
    logic  dneg_d;
    elem_t b_o [N_ELEM];
    elem_t det_o;
    logic  sing_o, ovf_o;
    logic  c_valid, c_ready, d_valid, d_ready;

    // Hold the threshold until a write; change it only while idle (the block does not enforce it).
    assign thr_next = cfg_we ? cfg_wdata : thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= '0;
        else          thr_reg <= thr_next;
    end

    // Unpack the nine elements, row by row.
    for (genvar k = 0; k < N_ELEM; k++) begin : g_unpack
        assign a_in[k] = s_tdata[k*ELEM_W +: ELEM_W];
    end

    // Exact cofactors from the 2x2 minors.
    mi3_cofactor u_cof (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a         (a_in),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .cof       (cof_c),
        .row0      (row0_c)
    );

    // Exact determinant by expansion along the first row, then its magnitude.
    mi3_det u_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .cof_in    (cof_c),
        .row0      (row0_c),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .cof_out   (cof_d),
        .dmag      (dmag_d),
        .dneg      (dneg_d)
    );

    // Rounded quotients of the adjugate over the determinant, saturated.
    // Singular matrices drop the quotients and return zero elements; det is still returned.
    mi3_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .cof       (cof_d),
        .dmag      (dmag_d),
        .dneg      (dneg_d),
        .thr       (thr_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .b         (b_o),
        .det       (det_o),
        .singular  (sing_o),
        .overflow  (ovf_o)
    );

    // Pack the result transaction.
    for (genvar k = 0; k < N_ELEM; k++) begin : g_pack
        assign m_tdata[k*ELEM_W +: ELEM_W] = b_o[k];
    end
    assign m_tdata[N_ELEM*ELEM_W +: ELEM_W] = det_o;
    assign m_tuser = {ovf_o, sing_o};

endmodule

@@ dv/mat3_inverse_tb.sv @@
// Self-checking testbench for mat3_inverse: streams 3x3 Q16.16 matrices, predicts the
// inverse, determinant and flags in exact wide arithmetic, and checks every result.
// Depends on mi3_pkg and the mat3_inverse RTL.
module mat3_inverse_tb import mi3_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int WD_LIMIT = 5000;   // cycles without any transaction before giving up
    localparam int DRAIN    = 60;     // pipeline is 40 deep; allow margin

    typedef elem_t matrix_t [N_ELEM];
    typedef struct packed {
        logic [(N_ELEM+1)*ELEM_W-1:0] data;
        logic [1:0]                   user;
    } inverse_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [THR_W-1:0]             cfg_wdata = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [N_ELEM*ELEM_W-1:0]     s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [(N_ELEM+1)*ELEM_W-1:0] m_tdata;
    logic [1:0]                   m_tuser;

    // Testbench copy of the threshold register and the pending expected inverses
    logic [THR_W-1:0] thr_shadow = '0;
    inverse_t         pending_inverses[$];
    int               n_errors = 0;
    int               idle_cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    always #1 aclk = ~aclk;

    mat3_inverse dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // a00,a01,a02,a10,...,a22 from bit 0
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // b00..b22, determinant from bit 0
        .m_tuser   (m_tuser)    // singular, overflow from bit 0
    );

    // Clamp a magnitude with sign to 32 bits; returns {overflow, value}.
    function automatic logic [ELEM_W:0] clamp_q(input logic [129:0] mag, input logic neg);
        logic [31:0] low;
        low = mag[31:0];
        if (neg) begin
            if (mag > 130'h8000_0000) return {1'b1, 32'h8000_0000};
            return {1'b0, 32'd0 - low};
        end
        if (mag > 130'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, low};
    endfunction

    // Exact inverse by adjugate over determinant, rounded half away from zero.
    function automatic inverse_t predict_inverse(input matrix_t m, input logic [THR_W-1:0] thr);
        logic signed [129:0] a[3][3];
        logic signed [129:0] cof[3][3];
        logic signed [129:0] det;
        logic signed [129:0] cv;
        logic [129:0]        dmag, mag, q, thr_wide;
        logic [ELEM_W:0]     sat;
        logic                dneg, sing, ovf;
        int                  r1, r2, c1, c2;
        inverse_t            res;
        res = '0;
        ovf = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r][c] = 130'(m[r*3+c]);
        for (int r = 0; r < 3; r++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                cof[r][c] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
                if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
            end
        end
        det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
        dneg = det < 0;
        dmag = dneg ? -det : det;
        thr_wide = 130'(thr) << (2 * FRAC);
        sing = dmag <= thr_wide;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!sing) begin
                    cv = cof[c][r];   // transposed cofactor
                    mag = (cv < 0) ? -cv : cv;
                    q = ((mag << (2 * FRAC + 1)) + dmag) / (dmag << 1);
                    sat = clamp_q(q, (cv < 0) != dneg);
                    ovf |= sat[ELEM_W];
                    res.data[(r*3+c)*ELEM_W +: ELEM_W] = sat[ELEM_W-1:0];
                end
            end
        end
        sat = clamp_q((dmag + (130'd1 << (2 * FRAC - 1))) >> (2 * FRAC), dneg);
        ovf |= sat[ELEM_W];
        res.data[N_ELEM*ELEM_W +: ELEM_W] = sat[ELEM_W-1:0];
        res.user = {ovf, sing};
        return res;
    endfunction

    // Receiver: stall at random per the current phase
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result transaction against the oldest expectation
    always @(posedge aclk) begin
        inverse_t exp_inv;
        string    fname;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_inverses.size() == 0) begin
                $error("result transaction with no matrix outstanding: %h", m_tdata);
                n_errors++;
            end else begin
                exp_inv = pending_inverses.pop_front();
                for (int k = 0; k <= N_ELEM; k++) begin
                    if (exp_inv.data[k*ELEM_W +: ELEM_W] !== m_tdata[k*ELEM_W +: ELEM_W]) begin
                        fname = (k == N_ELEM) ? "determinant" : $sformatf("b%0d%0d", k / 3, k % 3);
                        $error("%s expected %h actual %h", fname,
                               exp_inv.data[k*ELEM_W +: ELEM_W], m_tdata[k*ELEM_W +: ELEM_W]);
                        n_errors++;
                    end
                end
                if (exp_inv.user[0] !== m_tuser[0]) begin
                    $error("singular expected %b actual %b", exp_inv.user[0], m_tuser[0]);
                    n_errors++;
                end
                if (exp_inv.user[1] !== m_tuser[1]) begin
                    $error("overflow expected %b actual %b", exp_inv.user[1], m_tuser[1]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_inverses.size());
            $display("mat3_inverse_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one matrix; entered and left at a falling edge
    task automatic send_matrix(input matrix_t m);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid = 1'b1;
        for (int k = 0; k < N_ELEM; k++) s_tdata[k*ELEM_W +: ELEM_W] = m[k];
        do @(posedge aclk); while (!s_tready);
        pending_inverses.push_back(predict_inverse(m, thr_shadow));
        @(negedge aclk);
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic drain_pipeline();
        s_tvalid = 1'b0;
        wait (pending_inverses.size() == 0);
        repeat (DRAIN) @(negedge aclk);
    endtask

    // Write the threshold while the block is idle
    task automatic write_threshold(input logic [THR_W-1:0] v);
        drain_pipeline();
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        thr_shadow = v;
    endtask

    function automatic elem_t rand_elem(input int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
            2: return elem_t'($signed($urandom_range(0, 512)) - 256);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0001_0000;
                    3: return 32'sh0000_0001;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic matrix_t diag(input elem_t d0, input elem_t d1, input elem_t d2);
        matrix_t m;
        foreach (m[k]) m[k] = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    task automatic test_directed();
        matrix_t m;
        send_matrix(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));     // identity
        send_matrix(diag(32'sh2_0000, -32'sh4_0000, 32'sh0_8000));    // scaled, negative det
        send_matrix(diag(0, 0, 0));                                   // zero: singular at threshold 0
        send_matrix(diag(32'sh1, 32'sh1_0000, 32'sh1_0000));          // tiny pivot: inverse saturates
        send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF)); // det saturates
        send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000)); // most negative det
        send_matrix(diag(32'sh3_0000, 32'sh3_0000, 32'sh3_0000));     // 1/3: rounding
        send_matrix(diag(32'sh2, 32'sh2, 32'sh2));                    // det rounds to zero, not singular
        foreach (m[k]) m[k] = 32'sh7FFF_FFFF;                         // all max, singular
        send_matrix(m);
        foreach (m[k]) m[k] = (k % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        send_matrix(m);
        foreach (m[k]) m[k] = '0;                                     // permutation, odd
        m[1] = 32'sh1_0000; m[3] = 32'sh1_0000; m[8] = 32'sh1_0000;
        send_matrix(m);
        foreach (m[k]) m[k] = elem_t'((k + 1) << FRAC);               // rank two
        send_matrix(m);
        m[8] = 32'sh000A_0001;                                        // nudged off singular
        send_matrix(m);
        foreach (m[k]) m[k] = 32'sh8000_0000 >>> (k % 4);
        m[4] = 32'sh7FFF_FFFF;
        send_matrix(m);
        foreach (m[k]) m[k] = elem_t'(32'hFFFF_FFFF);                 // all -LSB
        m[0] = 32'sh5555_5555; m[4] = 32'shAAAA_AAAA; m[8] = 32'sh1234_5678;
        send_matrix(m);
    endtask

    // Equality with the threshold counts as singular
    task automatic test_threshold_edges();
        write_threshold(31'h0001_0000);
        send_matrix(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
        send_matrix(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0001));
        write_threshold(31'h0000_FFFF);
        send_matrix(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
        write_threshold(31'h7FFF_FFFF);
        send_matrix(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
        send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        write_threshold('0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [THR_W-1:0] thr, input int n_items);
        matrix_t m;
        int      kind, src;
        write_threshold(thr);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            kind = $urandom_range(0, 9);
            foreach (m[k]) m[k] = rand_elem(kind < 4 ? 0 : kind < 7 ? 1 : kind < 8 ? 2 : 3);
            if ($urandom_range(0, 9) == 0) begin
                // repeat a row so the determinant is exactly zero
                src = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++) m[((src + 1) % 3) * 3 + c] = m[src * 3 + c];
            end
            send_matrix(m);
        end
        drain_pipeline();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_threshold_edges();
        test_random_phase(0, 0, '0, 200);
        test_random_phase(57, 0, 31'($urandom_range(0, 1 << FRAC)), 200);
        test_random_phase(0, 57, 31'h7FFF_FFFF, 200);
        test_random_phase(27, 27, 31'($urandom), 200);
        drain_pipeline();
        if (n_errors == 0) begin
            $display("mat3_inverse_tb: PASS");
        end else begin
            $display("mat3_inverse_tb: FAIL");
        end
        $finish;
    end

endmodule
